// ----- hdl/fmv_pkg.sv -----
`timescale 1ns / 1ps
package fmv_pkg;

	localparam int unsigned MAX_BODY_LEN_DEF = 65535;

	localparam logic [7:0] SOH = 8'h01;
	localparam logic [31:0] TAG_SAT = 32'h8000_0000;
	localparam logic [3:0] BEGIN_LEN = 4'd10;
	localparam logic [3:0] TRAILER_LEN = 4'd7;
	localparam logic [3:0] POS_MAX = 4'd15;
	localparam logic [7:0] MSGTYPE_TAG = 8'd35;

	typedef enum logic [2:0] {
		PH_BEGIN   = 3'd0,
		PH_LENTAG  = 3'd1,
		PH_LEN     = 3'd2,
		PH_BODY    = 3'd3,
		PH_TRAILER = 3'd4,
		PH_DRAIN   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		KIND_VALUE   = 2'd0,
		KIND_FIELD   = 2'd1,
		KIND_VERDICT = 2'd2
	} kind_t;

	typedef enum logic [3:0] {
		V_OK         = 4'd0,
		V_BEGIN      = 4'd1,
		V_LEN_ORDER  = 4'd2,
		V_LEN_TRUNC  = 4'd3,
		V_LEN_BAD    = 4'd4,
		V_LEN_EXCEED = 4'd5,
		V_NOT_CKS    = 4'd6,
		V_CKS_FIELD  = 4'd7,
		V_MISMATCH   = 4'd8,
		V_FLD_TRUNC  = 4'd9,
		V_FLD_BAD    = 4'd10,
		V_TAG_BAD    = 4'd11,
		V_NO_MSGTYPE = 4'd12
	} verdict_t;

	// per-field error, first one wins
	typedef enum logic [1:0] {
		FE_NONE  = 2'd0,
		FE_BAD   = 2'd1,
		FE_TAG   = 2'd2,
		FE_TRUNC = 2'd3
	} ferr_t;

	// parser state with fixed widths
	typedef struct packed {
		phase_t      phase;
		logic [3:0]  pos;
		logic [7:0]  sum;
		logic [9:0]  cks;
		logic [31:0] tag;
		logic        tag_txt;
		logic        eq_seen;
		logic        tag_bad;
		logic        val_ne;
		ferr_t       ferr;
		verdict_t    first_err;
		logic        mt_seen;
		logic        mt_ok;
	} pstate_t;

	// one result item
	typedef struct packed {
		logic        emit;
		kind_t       kind;
		logic [30:0] tag;
		logic [7:0]  vbyte;
		verdict_t    code;
	} result_t;

	localparam pstate_t PSTATE_RST = '{
		phase: PH_BEGIN, pos: 4'd0, sum: 8'd0, cks: 10'd0, tag: 32'd0,
		tag_txt: 1'b0, eq_seen: 1'b0, tag_bad: 1'b0, val_ne: 1'b0,
		ferr: FE_NONE, first_err: V_OK, mt_seen: 1'b0, mt_ok: 1'b0
	};

	function automatic logic [7:0] begin_char(input logic [3:0] idx);
		logic [7:0] c;
		case (idx)
			4'd0: c = "8";
			4'd1: c = "=";
			4'd2: c = "F";
			4'd3: c = "I";
			4'd4: c = "X";
			4'd5: c = ".";
			4'd6: c = "4";
			4'd7: c = ".";
			4'd8: c = "4";
			4'd9: c = SOH;
			default: c = 8'd0;
		endcase
		return c;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= "0") && (b <= "9");
	endfunction

endpackage

// ----- hdl/fmv_step.sv -----
`timescale 1ns / 1ps
module fmv_step #(
	parameter int unsigned MAX_BODY_LEN = fmv_pkg::MAX_BODY_LEN_DEF,
	localparam int LW = $clog2(MAX_BODY_LEN + 2),
	localparam int BW = $clog2(MAX_BODY_LEN + 1)
) (
	input  fmv_pkg::pstate_t  st,
	input  logic [LW-1:0]     len_cur,
	input  logic [BW-1:0]     body_cur,
	input  logic [7:0]        in_byte,
	input  logic              end_of_message,
	output fmv_pkg::pstate_t  st_nx,
	output logic [LW-1:0]     len_nx,
	output logic [BW-1:0]     body_nx,
	output fmv_pkg::result_t  res,
	output fmv_pkg::verdict_t code
);

	fmv_pkg::pstate_t s;
	logic [LW-1:0] lacc;
	logic [BW-1:0] brem;
	logic [LW+3:0] lwide;
	logic [35:0]   twide;
	logic [3:0]    dig;
	logic          tag_ok;

	assign dig = in_byte[3:0] - 4'd0;
	assign lwide = ({4'd0, len_cur} << 3) + ({4'd0, len_cur} << 1) + (LW+4)'(dig);
	assign twide = ({4'd0, st.tag} << 3) + ({4'd0, st.tag} << 1) + 36'(dig);
	assign tag_ok = st.tag_txt && !st.tag_bad && (st.tag != 32'd0) &&
		(st.tag < fmv_pkg::TAG_SAT);

	// next state and body item
	always_comb begin
		s = st;
		lacc = len_cur;
		brem = body_cur;
		res = '{emit: 1'b0, kind: fmv_pkg::KIND_VALUE, tag: 31'd0, vbyte: 8'd0,
			code: fmv_pkg::V_OK};
		case (st.phase)
			fmv_pkg::PH_BEGIN: begin
				s.sum = st.sum + in_byte;
				if (st.pos < fmv_pkg::BEGIN_LEN && in_byte == fmv_pkg::begin_char(st.pos)) begin
					s.pos = st.pos + 4'd1;
					if (s.pos == fmv_pkg::BEGIN_LEN) begin
						s.phase = fmv_pkg::PH_LENTAG;
						s.pos = 4'd0;
					end
				end else begin
					s.first_err = fmv_pkg::V_BEGIN;
					s.phase = fmv_pkg::PH_DRAIN;
				end
			end
			fmv_pkg::PH_LENTAG: begin
				s.sum = st.sum + in_byte;
				if (in_byte == ((st.pos == 4'd0) ? 8'("9") : 8'("="))) begin
					s.pos = st.pos + 4'd1;
					if (s.pos >= 4'd2) begin
						s.phase = fmv_pkg::PH_LEN;
						s.pos = 4'd0;
					end
				end else begin
					s.first_err = fmv_pkg::V_LEN_ORDER;
					s.phase = fmv_pkg::PH_DRAIN;
				end
			end
			fmv_pkg::PH_LEN: begin
				s.sum = st.sum + in_byte;
				if (in_byte == fmv_pkg::SOH) begin
					if (!st.pos[0] || st.pos[1] || len_cur > LW'(MAX_BODY_LEN)) begin
						s.first_err = fmv_pkg::V_LEN_BAD;
						s.phase = fmv_pkg::PH_DRAIN;
					end else begin
						brem = BW'(len_cur);
						s.phase = (len_cur != '0) ? fmv_pkg::PH_BODY : fmv_pkg::PH_TRAILER;
						s.pos = 4'd0;
					end
				end else if (fmv_pkg::is_digit(in_byte)) begin
					s.pos[0] = 1'b1;
					if (lwide > (LW+4)'(MAX_BODY_LEN))
						lacc = LW'(MAX_BODY_LEN + 1);
					else
						lacc = lwide[LW-1:0];
				end else begin
					s.pos[1] = 1'b1;
				end
			end
			fmv_pkg::PH_BODY: begin
				s.sum = st.sum + in_byte;
				if (!st.eq_seen) begin
					if (in_byte == "=") begin
						s.eq_seen = 1'b1;
					end else if (in_byte == fmv_pkg::SOH) begin
						if (s.ferr == fmv_pkg::FE_NONE) s.ferr = fmv_pkg::FE_BAD;
						res.emit = 1'b1;
						res.kind = fmv_pkg::KIND_FIELD;
						s.tag_txt = 1'b0; s.eq_seen = 1'b0; s.tag_bad = 1'b0;
						s.val_ne = 1'b0; s.tag = 32'd0;
					end else begin
						s.tag_txt = 1'b1;
						if (fmv_pkg::is_digit(in_byte)) begin
							if (twide >= 36'(fmv_pkg::TAG_SAT)) begin
								s.tag = fmv_pkg::TAG_SAT;
								s.tag_bad = 1'b1;
							end else begin
								s.tag = twide[31:0];
							end
						end else begin
							s.tag_bad = 1'b1;
						end
					end
				end else if (in_byte == fmv_pkg::SOH) begin
					if (s.ferr == fmv_pkg::FE_NONE) begin
						if (!st.tag_txt) s.ferr = fmv_pkg::FE_BAD;
						else if (!tag_ok) s.ferr = fmv_pkg::FE_TAG;
					end
					if (tag_ok && st.tag == 32'(fmv_pkg::MSGTYPE_TAG) && !st.mt_seen) begin
						s.mt_seen = 1'b1;
						s.mt_ok = st.val_ne;
					end
					res.emit = 1'b1;
					res.kind = fmv_pkg::KIND_FIELD;
					res.tag = tag_ok ? st.tag[30:0] : 31'd0;
					s.tag_txt = 1'b0; s.eq_seen = 1'b0; s.tag_bad = 1'b0;
					s.val_ne = 1'b0; s.tag = 32'd0;
				end else begin
					s.val_ne = 1'b1;
					res.emit = 1'b1;
					res.kind = fmv_pkg::KIND_VALUE;
					res.tag = tag_ok ? st.tag[30:0] : 31'd0;
					res.vbyte = in_byte;
				end
				brem = body_cur - BW'(1);
				if (brem == '0) begin
					if ((s.tag_txt || s.eq_seen) && s.ferr == fmv_pkg::FE_NONE)
						s.ferr = fmv_pkg::FE_TRUNC;
					s.tag_txt = 1'b0; s.eq_seen = 1'b0; s.tag_bad = 1'b0;
					s.val_ne = 1'b0; s.tag = 32'd0;
					s.phase = fmv_pkg::PH_TRAILER;
					s.pos = 4'd0;
				end
			end
			fmv_pkg::PH_TRAILER: begin
				if ((st.pos == 4'd0 && in_byte != "1") ||
					(st.pos == 4'd1 && in_byte != "0") ||
					(st.pos == 4'd2 && in_byte != "=")) begin
					s.first_err = fmv_pkg::V_NOT_CKS;
				end else if (st.pos >= 4'd3 && st.pos <= 4'd5) begin
					if (fmv_pkg::is_digit(in_byte))
						s.cks = (st.cks << 3) + (st.cks << 1) + 10'(dig);
					else if (st.first_err == fmv_pkg::V_OK)
						s.first_err = fmv_pkg::V_CKS_FIELD;
				end
				if (st.pos < fmv_pkg::POS_MAX) s.pos = st.pos + 4'd1;
			end
			default: begin
			end
		endcase
	end

	// verdict from the state after this byte
	always_comb begin
		case (s.phase)
			fmv_pkg::PH_BEGIN:  code = fmv_pkg::V_BEGIN;
			fmv_pkg::PH_LENTAG: code = fmv_pkg::V_LEN_ORDER;
			fmv_pkg::PH_LEN:    code = fmv_pkg::V_LEN_TRUNC;
			fmv_pkg::PH_BODY:   code = fmv_pkg::V_LEN_EXCEED;
			fmv_pkg::PH_TRAILER: begin
				if (s.pos != fmv_pkg::TRAILER_LEN || in_byte != fmv_pkg::SOH)
					code = fmv_pkg::V_NOT_CKS;
				else if (s.first_err != fmv_pkg::V_OK)
					code = s.first_err;
				else if (s.cks > 10'd255)
					code = fmv_pkg::V_CKS_FIELD;
				else if (s.sum != s.cks[7:0])
					code = fmv_pkg::V_MISMATCH;
				else if (s.ferr == fmv_pkg::FE_TRUNC)
					code = fmv_pkg::V_FLD_TRUNC;
				else if (s.ferr == fmv_pkg::FE_BAD)
					code = fmv_pkg::V_FLD_BAD;
				else if (s.ferr == fmv_pkg::FE_TAG)
					code = fmv_pkg::V_TAG_BAD;
				else if (!(s.mt_seen && s.mt_ok))
					code = fmv_pkg::V_NO_MSGTYPE;
				else
					code = fmv_pkg::V_OK;
			end
			default: code = s.first_err;
		endcase
	end

	// final byte: verdict only, then back to reset state
	always_comb begin
		if (end_of_message) begin
			st_nx = fmv_pkg::PSTATE_RST;
			len_nx = '0;
			body_nx = '0;
		end else begin
			st_nx = s;
			len_nx = lacc;
			body_nx = brem;
		end
	end

endmodule

// ----- hdl/fix_message_validator.sv -----
`timescale 1ns / 1ps
// FIX 4.4 message validator. Takes one message byte per transfer, with
// end_of_message on the last byte, and accepts a new byte in every cycle as
// long as the output register is empty or being drained; each result is
// registered and appears in the cycle after its byte. Value bytes give value
// items (kind 0) and SOH gives field-end items (kind 1), both speculative;
// the last byte gives only the verdict item (kind 2) and the parser returns
// to its reset state. The body length limit is set by MAX_BODY_LEN.
module fix_message_validator #(
	parameter int unsigned MAX_BODY_LEN = fmv_pkg::MAX_BODY_LEN_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  item_kind,
	output logic [30:0] field_tag,
	output logic [7:0]  value_byte,
	output logic [3:0]  verdict_code
);

	localparam int LW = $clog2(MAX_BODY_LEN + 2);
	localparam int BW = $clog2(MAX_BODY_LEN + 1);

	fmv_pkg::pstate_t st_q, st_nx;
	logic [LW-1:0] len_q, len_nx;
	logic [BW-1:0] body_q, body_nx;
	fmv_pkg::result_t res;
	fmv_pkg::verdict_t vcode;
	logic out_valid_q;
	logic [1:0] kind_q;
	logic [30:0] tag_q;
	logic [7:0] vbyte_q;
	logic [3:0] code_q;
	logic in_xfer;

	assign in_ready = !out_valid_q || out_ready;
	assign in_xfer = in_valid && in_ready;

	fmv_step #(.MAX_BODY_LEN(MAX_BODY_LEN)) u_step (
		.st(st_q), .len_cur(len_q), .body_cur(body_q),
		.in_byte(in_byte), .end_of_message(end_of_message),
		.st_nx(st_nx), .len_nx(len_nx), .body_nx(body_nx), .res(res),
		.code(vcode)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= fmv_pkg::PSTATE_RST;
			len_q <= '0;
			body_q <= '0;
		end else if (in_xfer) begin
			st_q <= st_nx;
			len_q <= len_nx;
			body_q <= body_nx;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer && (res.emit || end_of_message)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (in_xfer && end_of_message) begin
			kind_q <= fmv_pkg::KIND_VERDICT;
			tag_q <= 31'd0;
			vbyte_q <= 8'd0;
			code_q <= vcode;
		end else if (in_xfer && res.emit) begin
			kind_q <= res.kind;
			tag_q <= res.tag;
			vbyte_q <= res.vbyte;
			code_q <= fmv_pkg::V_OK;
		end
	end

	assign out_valid = out_valid_q;
	assign item_kind = kind_q;
	assign field_tag = tag_q;
	assign value_byte = vbyte_q;
	assign verdict_code = code_q;

endmodule

// ----- hdl/fmv_checker.sv -----
`timescale 1ns / 1ps
module fmv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        end_of_message,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  item_kind,
	input logic [30:0] field_tag,
	input logic [7:0]  value_byte,
	input logic [3:0]  verdict_code
);

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(item_kind) &&
		$stable(field_tag) && $stable(value_byte) && $stable(verdict_code))
		else $error("stalled result changed");

	// last byte yields a verdict next cycle
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && end_of_message |=>
		out_valid && item_kind == fmv_pkg::KIND_VERDICT)
		else $error("missing verdict");

	// verdict carries no tag or byte, and a defined verdict code
	a_vfields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind == fmv_pkg::KIND_VERDICT |->
		field_tag == 31'd0 && value_byte == 8'd0 && verdict_code <= 4'd12)
		else $error("bad verdict fields");

	// body items carry no verdict code and a defined kind
	a_bfields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && item_kind != fmv_pkg::KIND_VERDICT |->
		verdict_code == 4'd0 && item_kind != 2'd3)
		else $error("bad body item");

endmodule

bind fix_message_validator fmv_checker u_fmv_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.end_of_message(end_of_message), .out_valid(out_valid), .out_ready(out_ready),
	.item_kind(item_kind), .field_tag(field_tag), .value_byte(value_byte),
	.verdict_code(verdict_code)
);
